>>> hdl/c2u_pkg.sv
package c2u_pkg;

	typedef enum logic [1:0] {
		MODE_UCS2 = 2'd0,
		MODE_UTF8 = 2'd1,
		MODE_EBU  = 2'd2,
		MODE_RSVD = 2'd3
	} char_mode_t;

	localparam char_mode_t CHAR_MODE_RESET = MODE_EBU;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_end;
	} out_word_t;

	// classified item between front and back
	typedef struct packed {
		logic        has_cp;
		logic [15:0] cp;
		logic        raw;
		logic [7:0]  raw_byte;
		logic        str_end;
	} job_t;

	function automatic logic [15:0] ebu_lookup(input logic [7:0] b);
		logic [15:0] r;
		begin
			case (b)
				8'h00: r = 16'h0000; 8'h01: r = 16'h0118; 8'h02: r = 16'h012e; 8'h03: r = 16'h0172;
				8'h04: r = 16'h0102; 8'h05: r = 16'h0116; 8'h06: r = 16'h010e; 8'h07: r = 16'h0218;
				8'h08: r = 16'h021a; 8'h09: r = 16'h010a; 8'h0a: r = 16'h000a; 8'h0b: r = 16'h000b;
				8'h0c: r = 16'h0120; 8'h0d: r = 16'h0139; 8'h0e: r = 16'h017b; 8'h0f: r = 16'h0143;
				8'h10: r = 16'h0105; 8'h11: r = 16'h0119; 8'h12: r = 16'h012f; 8'h13: r = 16'h0173;
				8'h14: r = 16'h0103; 8'h15: r = 16'h0117; 8'h16: r = 16'h010f; 8'h17: r = 16'h0219;
				8'h18: r = 16'h021b; 8'h19: r = 16'h010b; 8'h1a: r = 16'h0147; 8'h1b: r = 16'h011a;
				8'h1c: r = 16'h0121; 8'h1d: r = 16'h013a; 8'h1e: r = 16'h017c; 8'h1f: r = 16'h0082;
				8'h24: r = 16'h0142; 8'h5c: r = 16'h016e; 8'h5e: r = 16'h0141; 8'h60: r = 16'h0104;
				8'h7b: r = 16'h00ab; 8'h7c: r = 16'h016f; 8'h7d: r = 16'h00bb; 8'h7e: r = 16'h013d;
				8'h7f: r = 16'h0126;
				8'h80: r = 16'h00e1; 8'h81: r = 16'h00e0; 8'h82: r = 16'h00e9; 8'h83: r = 16'h00e8;
				8'h84: r = 16'h00ed; 8'h85: r = 16'h00ec; 8'h86: r = 16'h00f3; 8'h87: r = 16'h00f2;
				8'h88: r = 16'h00fa; 8'h89: r = 16'h00f9; 8'h8a: r = 16'h00d1; 8'h8b: r = 16'h00c7;
				8'h8c: r = 16'h015e; 8'h8d: r = 16'h00df; 8'h8e: r = 16'h00a1; 8'h8f: r = 16'h0178;
				8'h90: r = 16'h00e2; 8'h91: r = 16'h00e4; 8'h92: r = 16'h00ea; 8'h93: r = 16'h00eb;
				8'h94: r = 16'h00ee; 8'h95: r = 16'h00ef; 8'h96: r = 16'h00f4; 8'h97: r = 16'h00f6;
				8'h98: r = 16'h00fb; 8'h99: r = 16'h00fc; 8'h9a: r = 16'h00f1; 8'h9b: r = 16'h00e7;
				8'h9c: r = 16'h015f; 8'h9d: r = 16'h011f; 8'h9e: r = 16'h0131; 8'h9f: r = 16'h00ff;
				8'ha0: r = 16'h0136; 8'ha1: r = 16'h0145; 8'ha2: r = 16'h00a9; 8'ha3: r = 16'h0122;
				8'ha4: r = 16'h011e; 8'ha5: r = 16'h011b; 8'ha6: r = 16'h0148; 8'ha7: r = 16'h0151;
				8'ha8: r = 16'h0150; 8'ha9: r = 16'h20ac; 8'haa: r = 16'h00a3; 8'hab: r = 16'h0024;
				8'hac: r = 16'h0100; 8'had: r = 16'h0112; 8'hae: r = 16'h012a; 8'haf: r = 16'h016a;
				8'hb0: r = 16'h0137; 8'hb1: r = 16'h0146; 8'hb2: r = 16'h013b; 8'hb3: r = 16'h0123;
				8'hb4: r = 16'h013c; 8'hb5: r = 16'h0130; 8'hb6: r = 16'h0144; 8'hb7: r = 16'h0171;
				8'hb8: r = 16'h0170; 8'hb9: r = 16'h00bf; 8'hba: r = 16'h013e; 8'hbb: r = 16'h00b0;
				8'hbc: r = 16'h0101; 8'hbd: r = 16'h0113; 8'hbe: r = 16'h012b; 8'hbf: r = 16'h016b;
				8'hc0: r = 16'h00c1; 8'hc1: r = 16'h00c0; 8'hc2: r = 16'h00c9; 8'hc3: r = 16'h00c8;
				8'hc4: r = 16'h00cd; 8'hc5: r = 16'h00cc; 8'hc6: r = 16'h00d3; 8'hc7: r = 16'h00d2;
				8'hc8: r = 16'h00da; 8'hc9: r = 16'h00d9; 8'hca: r = 16'h0158; 8'hcb: r = 16'h010c;
				8'hcc: r = 16'h0160; 8'hcd: r = 16'h017d; 8'hce: r = 16'h00d0; 8'hcf: r = 16'h013f;
				8'hd0: r = 16'h00c2; 8'hd1: r = 16'h00c4; 8'hd2: r = 16'h00ca; 8'hd3: r = 16'h00cb;
				8'hd4: r = 16'h00ce; 8'hd5: r = 16'h00cf; 8'hd6: r = 16'h00d4; 8'hd7: r = 16'h00d6;
				8'hd8: r = 16'h00db; 8'hd9: r = 16'h00dc; 8'hda: r = 16'h0159; 8'hdb: r = 16'h010d;
				8'hdc: r = 16'h0161; 8'hdd: r = 16'h017e; 8'hde: r = 16'h0111; 8'hdf: r = 16'h0140;
				8'he0: r = 16'h00c3; 8'he1: r = 16'h00c5; 8'he2: r = 16'h00c6; 8'he3: r = 16'h0152;
				8'he4: r = 16'h0177; 8'he5: r = 16'h00dd; 8'he6: r = 16'h00d5; 8'he7: r = 16'h00d8;
				8'he8: r = 16'h00de; 8'he9: r = 16'h014a; 8'hea: r = 16'h0154; 8'heb: r = 16'h0106;
				8'hec: r = 16'h015a; 8'hed: r = 16'h0179; 8'hee: r = 16'h0164; 8'hef: r = 16'h00f0;
				8'hf0: r = 16'h00e3; 8'hf1: r = 16'h00e5; 8'hf2: r = 16'h00e6; 8'hf3: r = 16'h0153;
				8'hf4: r = 16'h0175; 8'hf5: r = 16'h00fd; 8'hf6: r = 16'h00f5; 8'hf7: r = 16'h00f8;
				8'hf8: r = 16'h00fe; 8'hf9: r = 16'h014b; 8'hfa: r = 16'h0155; 8'hfb: r = 16'h0107;
				8'hfc: r = 16'h015b; 8'hfd: r = 16'h017a; 8'hfe: r = 16'h0165; 8'hff: r = 16'h0127;
				default: r = {8'h00, b};
			endcase
			return r;
		end
	endfunction

endpackage

>>> hdl/c2u_front.sv
module c2u_front import c2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  char_mode_t mode,
	input  logic       in_vld,
	input  in_word_t   in_word,
	output logic       job_vld,
	output job_t       job
);

	logic [7:0] held_byte_q;
	logic       half_q;
	logic       start_q;
	logic       big_q;
	logic       stopped_q;

	logic        is_mark;
	logic        mark_big;
	logic [15:0] cp;
	logic        has_cp;
	logic        stop_now;

	always_comb begin
		is_mark  = 1'b0;
		mark_big = 1'b0;
		cp       = 16'h0000;
		has_cp   = 1'b0;
		case (mode)
			MODE_UTF8: begin
				has_cp = 1'b0;
			end
			MODE_UCS2: begin
				if (half_q) begin
					if (start_q && held_byte_q == 8'hfe && in_word.in_byte == 8'hff) begin
						is_mark  = 1'b1;
						mark_big = 1'b1;
					end else if (start_q && held_byte_q == 8'hff && in_word.in_byte == 8'hfe) begin
						is_mark = 1'b1;
					end else begin
						has_cp = 1'b1;
						cp = big_q ? {held_byte_q, in_word.in_byte} : {in_word.in_byte, held_byte_q};
					end
				end
			end
			default: begin
				has_cp = 1'b1;
				cp     = ebu_lookup(in_word.in_byte);
			end
		endcase
		stop_now = has_cp && cp == 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= 1'b0;
			start_q   <= 1'b1;
			big_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (in_vld) begin
			if (in_word.string_last) begin
				half_q    <= 1'b0;
				start_q   <= 1'b1;
				big_q     <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				if (mode == MODE_UCS2) begin
					half_q <= !half_q;
					if (half_q) start_q <= 1'b0;
					if (is_mark) big_q <= mark_big;
				end else begin
					half_q  <= 1'b0;
					start_q <= 1'b0;
				end
				if (stop_now) stopped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld && mode == MODE_UCS2 && !half_q) held_byte_q <= in_word.in_byte;
	end

	always_comb begin
		job_vld        = in_vld;
		job.has_cp     = has_cp && !stop_now && !stopped_q;
		job.cp         = cp;
		job.raw        = (mode == MODE_UTF8) && !stopped_q;
		job.raw_byte   = in_word.in_byte;
		job.str_end    = in_word.string_last;
	end

endmodule

>>> hdl/c2u_jobq.sv
module c2u_jobq import c2u_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic rd_vld,
	output job_t rd_job
);

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full   = cnt_q == 2'd2;
	assign rd_vld = cnt_q != 2'd0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_vld) else $error("job queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("job queue count out of range");
`endif

endmodule

>>> hdl/c2u_back.sv
module c2u_back import c2u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_vld,
	input  job_t      job,
	output logic      job_take,
	output logic      out_vld,
	output out_word_t out_word,
	input  logic      out_take
);

	logic [1:0] idx_q;
	logic [1:0] nbytes;
	logic [7:0] b;
	logic       lastb;
	logic       out_free;
	logic       emit;
	out_word_t  word_q;
	logic       full_q;

	always_comb begin
		if (job.has_cp) begin
			if (job.cp < 16'h0080) nbytes = 2'd1;
			else if (job.cp < 16'h0800) nbytes = 2'd2;
			else nbytes = 2'd3;
		end else if (job.raw) nbytes = 2'd1;
		else nbytes = 2'd0;
		b = 8'h00;
		if (job.raw) b = job.raw_byte;
		else if (nbytes == 2'd1) b = job.cp[7:0];
		else if (nbytes == 2'd2)
			b = (idx_q == 2'd0) ? (8'hc0 | {3'b000, job.cp[10:6]}) : (8'h80 | {2'b00, job.cp[5:0]});
		else if (nbytes == 2'd3) begin
			case (idx_q)
				2'd0:    b = 8'he0 | {4'h0, job.cp[15:12]};
				2'd1:    b = 8'h80 | {2'b00, job.cp[11:6]};
				default: b = 8'h80 | {2'b00, job.cp[5:0]};
			endcase
		end
		lastb    = (nbytes == 2'd0) || (idx_q == nbytes - 2'd1);
		out_free = !full_q || out_take;
		emit     = job_vld && out_free && (nbytes != 2'd0 || job.str_end);
		job_take = job_vld && (nbytes == 2'd0 ? (!job.str_end || out_free) : (out_free && lastb));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 2'd0;
			full_q <= 1'b0;
		end else begin
			if (job_take) idx_q <= 2'd0;
			else if (emit) idx_q <= idx_q + 2'd1;
			if (emit) full_q <= 1'b1;
			else if (out_take) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q.utf8_byte  <= b;
			word_q.byte_valid <= nbytes != 2'd0;
			word_q.run_last   <= lastb;
			word_q.string_end <= lastb && job.str_end;
		end
	end

	assign out_vld  = full_q;
	assign out_word = word_q;

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3) else $error("byte index out of range");
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && word_q.string_end) |-> word_q.run_last) else $error("string end without run end");
	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !word_q.byte_valid) |-> word_q.string_end) else $error("bare word without end");
`endif

endmodule

>>> hdl/charset_to_utf8_stream.sv
// timing: a word is classified and queued at its accepting edge; its first utf8 byte is
//   then moved from the queue into the output register once that register is free
// throughput: one input word per cycle when it makes one byte and the queue is not full;
//   the encoder emits one byte a cycle while the output is free, so a three-byte word holds the back end
// reset: arst_n clears the queue, output register and string state; char_mode returns to ebu latin
module charset_to_utf8_stream import c2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	input  logic       push,
	input  in_word_t   in_data,
	output logic       full,
	output logic       empty,
	output out_word_t  out_data,
	input  logic       pop
);

	char_mode_t mode_q;
	logic       acc;
	logic       job_vld;
	job_t       job;
	logic       q_full;
	logic       q_vld;
	job_t       q_job;
	logic       q_take;
	logic       ovld;

	// mode register; the user must write it only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= CHAR_MODE_RESET;
		else if (cfg_we) mode_q <= char_mode_t'(cfg_data);
	end

	assign full = q_full;
	assign acc  = push && !q_full;

	// front: pairs ucs-2 bytes, handles byte-order marks, maps ebu latin, passes utf-8 bytes raw
	c2u_front u_front (
		.clk(clk), .arst_n(arst_n), .mode(mode_q),
		.in_vld(acc), .in_word(in_data),
		.job_vld(job_vld), .job(job)
	);

	// two-entry job queue decouples classification from encoding
	c2u_jobq u_jobq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(job_vld), .wr_job(job), .full(q_full),
		.rd_en(q_take), .rd_vld(q_vld), .rd_job(q_job)
	);

	// back: utf-8 encoder, one byte per cycle into the output register while that register is free
	c2u_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_vld(q_vld), .job(q_job), .job_take(q_take),
		.out_vld(ovld), .out_word(out_data), .out_take(pop && ovld)
	);

	assign empty = !ovld;

`ifndef SYNTHESIS
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld && !pop) |=> ovld) else $error("output word lost");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !acc) else $error("accepted while full");
	a_empty_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(out_data)) else $error("output word changed");
`endif

endmodule
